// ===== sv/orl_pkg.sv =====
// Shared types, constants and helpers of the ordered record list unit.
// No dependencies; orl_ctrl and the top module refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package orl_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((LEN_W > 8) ? LEN_W : 8) + 1;

  localparam int KEY_W  = 64;
  localparam int NAME_W = 64;
  localparam int AGE_W  = 8;
  localparam int REC_W  = KEY_W + NAME_W + AGE_W;

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 160;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4,
    CMD_FIND   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_NOKEY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_PUT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [7:0]        position;
    logic [KEY_W-1:0]  item_key;
    logic [NAME_W-1:0] item_name;
    logic [AGE_W-1:0]  item_age;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name;
    logic [AGE_W-1:0]  age;
  } rec_t;

  typedef struct packed {
    status_e           status;
    logic [7:0]        found_position;
    logic [KEY_W-1:0]  out_key;
    logic [NAME_W-1:0] out_name;
    logic [AGE_W-1:0]  out_age;
    logic [7:0]        list_length;
  } res_t;

  function automatic logic [7:0] low_byte(input logic [CMP_W-1:0] v);
    return v[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/orl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module orl_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 136
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/orl_ctrl.sv =====
// Command sequencer of the ordered record list: decode, position checks and
// the walk over the record RAM. Depends on orl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module orl_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cmd_valid,
  output logic                            cmd_ready,
  input  wire orl_pkg::cmd_t              cmd_in,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output orl_pkg::res_t                   res,
  output logic                            we,
  output logic [orl_pkg::ADDR_W-1:0]      waddr,
  output logic [orl_pkg::REC_W-1:0]       wdata,
  output logic                            re,
  output logic [orl_pkg::ADDR_W-1:0]      raddr,
  input  wire logic [orl_pkg::REC_W-1:0]  rdata
);

  orl_pkg::state_e                 state, state_next;
  orl_pkg::cmd_t                   op, op_next;
  logic [orl_pkg::LEN_W-1:0]       len, len_next;
  logic [orl_pkg::ADDR_W-1:0]      idx, idx_next;
  logic [orl_pkg::ADDR_W-1:0]      last, last_next;
  logic [orl_pkg::ADDR_W-1:0]      pipe_addr, pipe_addr_next;
  logic                            pipe_v, pipe_v_next;
  logic                            issue_done, issue_done_next;
  orl_pkg::status_e                status, status_next;
  logic [7:0]                      fpos, fpos_next;
  orl_pkg::rec_t                   orec, orec_next;

  orl_pkg::rec_t                   rd_rec;
  orl_pkg::rec_t                   new_rec;
  orl_pkg::cmd_e                   opcode;
  logic [orl_pkg::CMP_W-1:0]       len_w, pos_w, len_m1, pos_m1, len_p1, pipe_p1;
  logic                            full;

  assign rd_rec  = orl_pkg::rec_t'(rdata);
  assign new_rec = '{key: op.item_key, name: op.item_name, age: op.item_age};
  assign opcode  = orl_pkg::cmd_e'(op.cmd);
  assign len_w   = orl_pkg::CMP_W'(len);
  assign pos_w   = orl_pkg::CMP_W'(op.position);
  assign len_m1  = len_w - orl_pkg::CMP_W'(1);
  assign len_p1  = len_w + orl_pkg::CMP_W'(1);
  assign pos_m1  = pos_w - orl_pkg::CMP_W'(1);
  assign pipe_p1 = orl_pkg::CMP_W'(pipe_addr) + orl_pkg::CMP_W'(1);
  assign full    = (len == orl_pkg::LEN_W'(orl_pkg::CAPACITY));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= orl_pkg::S_IDLE;
      len   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    idx        <= idx_next;
    last       <= last_next;
    pipe_addr  <= pipe_addr_next;
    pipe_v     <= pipe_v_next;
    issue_done <= issue_done_next;
    status     <= status_next;
    fpos       <= fpos_next;
    orec       <= orec_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    len_next        = len;
    idx_next        = idx;
    last_next       = last;
    pipe_addr_next  = pipe_addr;
    pipe_v_next     = pipe_v;
    issue_done_next = issue_done;
    status_next     = status;
    fpos_next       = fpos;
    orec_next       = orec;
    cmd_ready       = 1'b0;
    res_valid       = 1'b0;
    we              = 1'b0;
    waddr           = pos_m1[orl_pkg::ADDR_W-1:0];
    wdata           = new_rec;
    re              = 1'b0;
    raddr           = idx;

    case (state)
      orl_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          op_next    = cmd_in;
          state_next = orl_pkg::S_DECODE;
        end
      end

      orl_pkg::S_DECODE: begin
        status_next     = orl_pkg::ST_OK;
        fpos_next       = '0;
        orec_next       = '0;
        pipe_v_next     = 1'b0;
        issue_done_next = 1'b0;
        state_next      = orl_pkg::S_FIN;
        case (opcode)
          orl_pkg::CMD_CLEAR: begin
            len_next = '0;
          end
          orl_pkg::CMD_APPEND: begin
            if (full) begin
              status_next = orl_pkg::ST_FULL;
            end else begin
              we        = 1'b1;
              waddr     = len[orl_pkg::ADDR_W-1:0];
              len_next  = len + orl_pkg::LEN_W'(1);
              fpos_next = orl_pkg::low_byte(len_p1);
            end
          end
          orl_pkg::CMD_INSERT: begin
            if (full) begin
              status_next = orl_pkg::ST_FULL;
            end else if (pos_w == '0 || pos_w > len_p1) begin
              status_next = orl_pkg::ST_BADPOS;
            end else if (pos_w == len_p1) begin
              state_next = orl_pkg::S_PUT;
            end else begin
              idx_next   = len_m1[orl_pkg::ADDR_W-1:0];
              last_next  = pos_m1[orl_pkg::ADDR_W-1:0];
              state_next = orl_pkg::S_WALK;
            end
          end
          orl_pkg::CMD_DELETE: begin
            if (pos_w == '0 || pos_w > len_w) begin
              status_next = orl_pkg::ST_BADPOS;
            end else if (pos_w == len_w) begin
              len_next = len - orl_pkg::LEN_W'(1);
            end else begin
              idx_next   = pos_w[orl_pkg::ADDR_W-1:0];
              last_next  = len_m1[orl_pkg::ADDR_W-1:0];
              state_next = orl_pkg::S_WALK;
            end
          end
          orl_pkg::CMD_READ: begin
            if (pos_w == '0 || pos_w > len_w) begin
              status_next = orl_pkg::ST_BADPOS;
            end else begin
              idx_next   = pos_m1[orl_pkg::ADDR_W-1:0];
              last_next  = pos_m1[orl_pkg::ADDR_W-1:0];
              state_next = orl_pkg::S_WALK;
            end
          end
          orl_pkg::CMD_FIND: begin
            if (len == '0) begin
              status_next = orl_pkg::ST_NOKEY;
            end else begin
              idx_next   = '0;
              last_next  = len_m1[orl_pkg::ADDR_W-1:0];
              state_next = orl_pkg::S_WALK;
            end
          end
          default: begin
          end
        endcase
      end

      orl_pkg::S_WALK: begin
        re = !issue_done;
        if (pipe_v) begin
          case (opcode)
            orl_pkg::CMD_INSERT: begin
              we    = 1'b1;
              waddr = pipe_addr + orl_pkg::ADDR_W'(1);
              wdata = rdata;
              if (issue_done) begin
                state_next = orl_pkg::S_PUT;
              end
            end
            orl_pkg::CMD_DELETE: begin
              we    = 1'b1;
              waddr = pipe_addr - orl_pkg::ADDR_W'(1);
              wdata = rdata;
              if (issue_done) begin
                len_next   = len - orl_pkg::LEN_W'(1);
                state_next = orl_pkg::S_FIN;
              end
            end
            default: begin
              if (opcode == orl_pkg::CMD_READ || rd_rec.key == op.item_key) begin
                status_next = orl_pkg::ST_OK;
                fpos_next   = orl_pkg::low_byte(pipe_p1);
                orec_next   = rd_rec;
                state_next  = orl_pkg::S_FIN;
              end else if (issue_done) begin
                status_next = orl_pkg::ST_NOKEY;
                state_next  = orl_pkg::S_FIN;
              end
            end
          endcase
        end
        if (!issue_done) begin
          pipe_v_next    = 1'b1;
          pipe_addr_next = idx;
          if (idx == last) begin
            issue_done_next = 1'b1;
          end else if (opcode == orl_pkg::CMD_INSERT) begin
            idx_next = idx - orl_pkg::ADDR_W'(1);
          end else begin
            idx_next = idx + orl_pkg::ADDR_W'(1);
          end
        end else begin
          pipe_v_next = 1'b0;
        end
      end

      orl_pkg::S_PUT: begin
        we         = 1'b1;
        len_next   = len + orl_pkg::LEN_W'(1);
        fpos_next  = orl_pkg::low_byte(pos_w);
        state_next = orl_pkg::S_FIN;
      end

      orl_pkg::S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = orl_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = orl_pkg::S_IDLE;
      end
    endcase
  end

  assign res = '{
    status:         status,
    found_position: fpos,
    out_key:        orec.key,
    out_name:       orec.name,
    out_age:        orec.age,
    list_length:    orl_pkg::low_byte(len_w)
  };

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= orl_pkg::LEN_W'(orl_pkg::CAPACITY))
    else $error("list length above capacity");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == orl_pkg::S_DECODE || state == orl_pkg::S_WALK
            || state == orl_pkg::S_PUT))
    else $error("record write outside a command");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("read and write on one entry in one cycle");

  a_fin_release: assert property (@(posedge clk) disable iff (rst)
    (state == orl_pkg::S_FIN && res_ready) |=> state == orl_pkg::S_IDLE)
    else $error("result taken but sequencer not idle");

  a_walk_pipe: assert property (@(posedge clk) disable iff (rst)
    (state == orl_pkg::S_WALK && issue_done) |-> pipe_v || $past(pipe_v))
    else $error("walk finished issuing with nothing in flight");

endmodule

`default_nettype wire

// ===== sv/ordered_record_list_unit.sv =====
// Ordered record list unit: a 1-based list of up to 128 records held in
// one record RAM, driven by a command sequencer, results through an output
// register. Rate: an input beat is taken only while the sequencer is idle.
// Clear, append, unused codes and failed commands finish in decode; insert
// at len+1 and delete of the last record need no walk either. Insert at
// p <= len shifts len-p+1 records. Read, find, the other inserts and deletes
// walk over the record RAM; insert and delete write each record read back
// one place up or down. The output register lets the next beat in while a
// result still waits on the master side.
`timescale 1ns / 1ps
`default_nettype none

module ordered_record_list_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // cmd[2:0], position[10:3], item_key[74:11], item_name[138:75],
  // item_age[146:139], zero pad above
  input  wire logic [orl_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // status[1:0], found_position[9:2], out_key[73:10], out_name[137:74],
  // out_age[145:138], list_length[153:146], zero pad above
  output logic      [orl_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  orl_pkg::cmd_t                 cmd_in;
  orl_pkg::res_t                 res;
  orl_pkg::res_t                 out_res;
  logic                          res_valid;
  logic                          res_ready;
  logic                          out_v;
  logic                          we;
  logic                          re;
  logic [orl_pkg::ADDR_W-1:0]    waddr;
  logic [orl_pkg::ADDR_W-1:0]    raddr;
  logic [orl_pkg::REC_W-1:0]     wdata;
  logic [orl_pkg::REC_W-1:0]     rdata;

  assign cmd_in = '{
    cmd:       s_tdata[2:0],
    position:  s_tdata[10:3],
    item_key:  s_tdata[74:11],
    item_name: s_tdata[138:75],
    item_age:  s_tdata[146:139]
  };

  orl_ram #(
    .DEPTH (orl_pkg::CAPACITY),
    .WIDTH (orl_pkg::REC_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  orl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .cmd_in    (cmd_in),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  assign res_ready = !out_v || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = orl_pkg::OUT_TDATA_W'({
    out_res.list_length,
    out_res.out_age,
    out_res.out_name,
    out_res.out_key,
    out_res.found_position,
    out_res.status
  });

endmodule

`default_nettype wire
